// ===== rtl/core/mesh_recenter_scale_normals_macros.svh =====
// assertion macros shared by the rtl files
`ifndef MESH_RECENTER_SCALE_NORMALS_MACROS_SVH
`define MESH_RECENTER_SCALE_NORMALS_MACROS_SVH

`ifndef SYNTHESIS
`define MRSN_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MRSN_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MRSN_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MRSN_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/mrsn_pkg.sv =====
package mrsn_pkg;

   localparam int CMD_W       = 2;
   localparam int IDX_W       = 10;
   localparam int COORD_W     = 32;
   localparam int SUM_W       = 48;
   localparam int NRM_W       = 18;
   localparam int NUM_COORDS  = 9;
   localparam int NUM_AXES    = 3;
   localparam int DIV_NUM_W   = 52;
   localparam int DIV_DEN_W   = 35;
   localparam int ARITH_W     = 64;
   localparam int STEP_W      = 7;
   localparam int SQRT_STEPS  = 32;
   localparam int EDGE_W      = 31;
   localparam int REQ_TDATA_W = 304;
   localparam int RSP_TDATA_W = 344;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } arith_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_sts_type;

   // saturate a rounded magnitude with its sign to signed 32 bits
   function automatic logic [COORD_W-1:0] sat32(input logic [DIV_NUM_W-1:0] q,
                                                input logic neg);
      logic [DIV_NUM_W-1:0] n;
      n = -q;
      if (neg) begin
         if (q > DIV_NUM_W'(64'h8000_0000)) return 32'h8000_0000;
         return n[COORD_W-1:0];
      end
      if (q > DIV_NUM_W'(64'h7FFF_FFFF)) return 32'h7FFF_FFFF;
      return q[COORD_W-1:0];
   endfunction

endpackage

// ===== rtl/core/mrsn_ram.sv =====
module mrsn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 9216
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/mrsn_arith.sv =====
`include "mesh_recenter_scale_normals_macros.svh"

module mrsn_arith (
   input  logic                              clock,
   input  logic                              reset,
   input  mrsn_pkg::arith_ctl_type           ctl,
   input  logic [mrsn_pkg::ARITH_W-1:0]      opa,
   input  logic [mrsn_pkg::DIV_DEN_W-1:0]    opb,
   output mrsn_pkg::arith_sts_type           sts,
   output logic [mrsn_pkg::ARITH_W-1:0]      result
);

   localparam int W = mrsn_pkg::ARITH_W;
   localparam int NW = mrsn_pkg::DIV_NUM_W;
   localparam int SW = mrsn_pkg::STEP_W;

   logic          mode_ff, mode_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  z_ff, z_in;

   logic [W-1:0] rem_sh, sub_a, sub_b;
   logic [W:0]   diff;
   logic         ge;

   // shared compare and subtract: remainder step or root trial
   always_comb begin
      rem_sh = {x_ff[W-2:0], y_ff[NW-1]};
      sub_a  = mode_ff ? x_ff : rem_sh;
      sub_b  = mode_ff ? (y_ff + z_ff) : z_ff;
      diff   = {1'b0, sub_a} - {1'b0, sub_b};
      ge     = !diff[W];
   end

   always_comb begin
      mode_in = mode_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (ctl.start) begin
         mode_in = ctl.sqrt_mode;
         busy_in = 1'b1;
         if (ctl.sqrt_mode) begin
            x_in   = opa;
            y_in   = '0;
            z_in   = W'(1) << (W - 2);
            cnt_in = SW'(mrsn_pkg::SQRT_STEPS);
         end else begin
            x_in   = '0;
            y_in   = W'(opa[NW-1:0]);
            z_in   = W'(opb);
            cnt_in = SW'(NW);
         end
      end else if (busy_ff) begin
         if (mode_ff) begin
            if (ge) begin
               x_in = diff[W-1:0];
               y_in = (y_ff >> 1) + z_ff;
            end else begin
               y_in = y_ff >> 1;
            end
            z_in = z_ff >> 2;
         end else begin
            x_in = ge ? diff[W-1:0] : rem_sh;
            y_in = {y_ff[W-2:0], ge};
         end
         cnt_in = cnt_ff - SW'(1);
         if (cnt_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = mode_ff ? y_ff : W'(y_ff[NW-1:0]);

   `MRSN_ASSERT_IMP(a_start_when_free, clock, reset, ctl.start, !busy_ff)
   `MRSN_ASSERT_NXT(a_start_busy, clock, reset, ctl.start, busy_ff)
   `MRSN_ASSERT_NXT(a_last_step_done, clock, reset, busy_ff && (cnt_ff == SW'(1)), done_ff)
   `MRSN_ASSERT_IMP(a_done_not_busy, clock, reset, done_ff, !busy_ff)

endmodule

// ===== rtl/core/mesh_recenter_scale_normals.sv =====
// mesh_recenter_scale_normals
// requests enter on req_* (command in req_tuser); a read request gives one result on rsp_*.
// clear request: no result. load request: the nine coordinates are written to the
// triangle store one word a cycle while the axis sums and the largest magnitude are updated,
// no result; a load when the store is full is dropped.
// read request: one result. the pace is set by the shared divide / square-root unit, which
// retires one quotient or root bit per cycle: three centroid divides, nine vertex divides,
// one root and three normal divides, plus the cross-product and sum-of-squares products
// through one 32x32 multiplier and a normalize shift of one bit a cycle. an out-of-range
// index, an empty extent or a zero cross product returns zeros. req_tready is high only
// while the block is idle, so one request is worked on at a time.
// the result sits in an output register until rsp_tready; a stalled receiver holds the
// block at the end of the next read, loads and clears still pass.
// reset (synchronous, active high) empties the store: count, sums and extent go to zero.
`include "mesh_recenter_scale_normals_macros.svh"

module mesh_recenter_scale_normals #(
   parameter int MAX_TRIANGLES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // index, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad
   input  logic [mrsn_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // command
   input  logic [mrsn_pkg::CMD_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_a_x .. out_c_z, normal_x, normal_y, normal_z, zero pad
   output logic [mrsn_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int CW     = mrsn_pkg::COORD_W;
   localparam int IW     = mrsn_pkg::IDX_W;
   localparam int NC     = mrsn_pkg::NUM_COORDS;
   localparam int NA     = mrsn_pkg::NUM_AXES;
   localparam int SMW    = mrsn_pkg::SUM_W;
   localparam int NW     = mrsn_pkg::DIV_NUM_W;
   localparam int DW     = mrsn_pkg::DIV_DEN_W;
   localparam int AW     = mrsn_pkg::ARITH_W;
   localparam int EW     = mrsn_pkg::EDGE_W;
   localparam int RW     = mrsn_pkg::NRM_W;
   localparam int DEPTH  = MAX_TRIANGLES * NC;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(MAX_TRIANGLES + 1);
   localparam int CMP_W  = (CNT_W > IW) ? CNT_W : IW;
   localparam int D3_W   = CNT_W + 2;
   localparam int NV_OFF = NC * CW;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_CHECK, ST_CEN, ST_CEN_WAIT, ST_VRD, ST_VDAT, ST_VWAIT,
      ST_EDGE, ST_CROSS, ST_ZCHK, ST_NORM, ST_SQ, ST_SQRT_GO, ST_SQRT_WAIT,
      ST_NDIV, ST_NDIV_WAIT, ST_OUT, ST_ZERO
   } st_type;

   st_type                  st_ff, st_in;
   logic [CW-1:0]           crd_ff [NC], crd_in [NC];
   logic [IW-1:0]           idx_ff, idx_in;
   logic [3:0]              k_ff, k_in;
   logic [1:0]              ax_ff, ax_in;
   logic [2:0]              stp_ff, stp_in;
   logic [SMW-1:0]          sum_ff [NA], sum_in [NA];
   logic [CW-1:0]           lg_ff, lg_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [ADDR_W-1:0]       waddr_ff, waddr_in;
   logic [ADDR_W-1:0]       rbase_ff, rbase_in;
   logic [CW-1:0]           cen_ff [NA], cen_in [NA];
   logic [DW-1:0]           den5_ff, den5_in;
   logic                    vneg_ff, vneg_in;
   logic [CW-1:0]           v_ff [NC], v_in [NC];
   logic signed [EW-1:0]    e1_ff [NA], e1_in [NA];
   logic signed [EW-1:0]    e2_ff [NA], e2_in [NA];
   logic signed [AW-1:0]    c_ff [NA], c_in [NA];
   logic [AW-1:0]           m_ff [NA], m_in [NA];
   logic                    cneg_ff [NA], cneg_in [NA];
   logic signed [AW-1:0]    prod_ff, prod_in;
   logic [AW-1:0]           s2_ff, s2_in;
   logic [CW-1:0]           r_ff, r_in;
   logic [RW-1:0]           nrm_ff [NA], nrm_in [NA];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [mrsn_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_raddr;
   logic [CW-1:0]           ram_rdata;

   mrsn_pkg::arith_ctl_type actl;
   mrsn_pkg::arith_sts_type asts;
   logic [AW-1:0]           a_opa, a_res;
   logic [DW-1:0]           a_opb;

   mrsn_pkg::cmd_type       cmd;
   logic                    accept;
   logic [CW-1:0]           req_crd [NC];
   logic [SMW-1:0]          s_cur, s_mag;
   logic [D3_W-1:0]         d3;
   logic [NW-1:0]           cnum, vnum, nnum;
   logic [CW:0]             vd, vmag;
   logic [CW:0]             ed1 [NA], ed2 [NA], em1 [NA], em2 [NA], es1 [NA], es2 [NA];
   logic                    big;
   logic signed [CW-1:0]    mul_a, mul_b;
   logic [1:0]              acc_i;
   logic [NW-1:0]           q_cur;
   logic [CW-1:0]           wcrd, wmag;
   logic [RW-1:0]           qn;
   logic [ADDR_W+IW+3:0]    rbase_w;
   logic [CNT_W+3:0]        wbase_w;

   assign cmd    = mrsn_pkg::cmd_type'(req_tuser);
   assign accept = req_tvalid && req_tready;
   assign req_tready = (st_ff == ST_IDLE);

   mrsn_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr_ff),
      .wdata (crd_ff[k_ff]),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   mrsn_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (actl),
      .opa    (a_opa),
      .opb    (a_opb),
      .sts    (asts),
      .result (a_res)
   );

   // operand shaping
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         req_crd[i] = req_tdata[IW + i*CW +: CW];
      end
      ram_we    = (st_ff == ST_LOAD);
      ram_raddr = rbase_ff + ADDR_W'(k_ff);
      rbase_w   = (ADDR_W+IW+4)'({idx_ff, 3'b000}) + (ADDR_W+IW+4)'(idx_ff);
      wbase_w   = (CNT_W+4)'({cnt_ff, 3'b000}) + (CNT_W+4)'(cnt_ff);
      wcrd      = crd_ff[k_ff];
      wmag      = wcrd[CW-1] ? -wcrd : wcrd;

      s_cur = sum_ff[ax_ff];
      s_mag = s_cur[SMW-1] ? -s_cur : s_cur;
      d3    = D3_W'({cnt_ff, 1'b0}) + D3_W'(cnt_ff);
      cnum  = NW'(s_mag) + NW'(d3 >> 1);

      vd    = {ram_rdata[CW-1], ram_rdata} - {cen_ff[ax_ff][CW-1], cen_ff[ax_ff]};
      vmag  = vd[CW] ? -vd : vd;
      vnum  = NW'({vmag, 18'b0}) + NW'(den5_ff >> 1);

      nnum  = NW'({m_ff[ax_ff][29:0], 16'b0}) + NW'(r_ff >> 1);
      q_cur = a_res[NW-1:0];
      qn    = cneg_ff[ax_ff] ? -q_cur[RW-1:0] : q_cur[RW-1:0];

      big = 1'b0;
      for (int i = 0; i < NA; i++) begin
         ed1[i] = {v_ff[3+i][CW-1], v_ff[3+i]} - {v_ff[i][CW-1], v_ff[i]};
         ed2[i] = {v_ff[6+i][CW-1], v_ff[6+i]} - {v_ff[i][CW-1], v_ff[i]};
         em1[i] = ed1[i][CW] ? -ed1[i] : ed1[i];
         em2[i] = ed2[i][CW] ? -ed2[i] : ed2[i];
         if (em1[i][CW:30] != '0 || em2[i][CW:30] != '0) big = 1'b1;
      end
      for (int i = 0; i < NA; i++) begin
         es1[i] = big ? (em1[i] >> 3) : em1[i];
         es2[i] = big ? (em2[i] >> 3) : em2[i];
      end

      mul_a = '0;
      mul_b = '0;
      if (st_ff == ST_SQ) begin
         if (stp_ff < 3'd3) begin
            mul_a = m_ff[stp_ff[1:0]][CW-1:0];
            mul_b = m_ff[stp_ff[1:0]][CW-1:0];
         end
      end else begin
         case (stp_ff)
            3'd0: begin mul_a = CW'(e1_ff[1]); mul_b = CW'(e2_ff[2]); end
            3'd1: begin mul_a = CW'(e1_ff[2]); mul_b = CW'(e2_ff[1]); end
            3'd2: begin mul_a = CW'(e1_ff[2]); mul_b = CW'(e2_ff[0]); end
            3'd3: begin mul_a = CW'(e1_ff[0]); mul_b = CW'(e2_ff[2]); end
            3'd4: begin mul_a = CW'(e1_ff[0]); mul_b = CW'(e2_ff[1]); end
            3'd5: begin mul_a = CW'(e1_ff[1]); mul_b = CW'(e2_ff[0]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
      prod_in = mul_a * mul_b;
      acc_i   = 2'((stp_ff - 3'd1) >> 1);

      actl.start     = 1'b0;
      actl.sqrt_mode = 1'b0;
      a_opa = '0;
      a_opb = '0;
      case (st_ff)
         ST_CEN: begin
            actl.start = 1'b1;
            a_opa = AW'(cnum);
            a_opb = DW'(d3);
         end
         ST_VDAT: begin
            actl.start = 1'b1;
            a_opa = AW'(vnum);
            a_opb = den5_ff;
         end
         ST_SQRT_GO: begin
            actl.start     = 1'b1;
            actl.sqrt_mode = 1'b1;
            a_opa = s2_ff;
         end
         ST_NDIV: begin
            actl.start = 1'b1;
            a_opa = AW'(nnum);
            a_opb = DW'(r_ff);
         end
         default: begin
            actl.start = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      st_in        = st_ff;
      crd_in       = crd_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      ax_in        = ax_ff;
      stp_in       = stp_ff;
      sum_in       = sum_ff;
      lg_in        = lg_ff;
      cnt_in       = cnt_ff;
      waddr_in     = waddr_ff;
      rbase_in     = rbase_ff;
      cen_in       = cen_ff;
      den5_in      = den5_ff;
      vneg_in      = vneg_ff;
      v_in         = v_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      c_in         = c_ff;
      m_in         = m_ff;
      cneg_in      = cneg_ff;
      s2_in        = s2_ff;
      r_in         = r_ff;
      nrm_in       = nrm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  mrsn_pkg::CMD_CLEAR: begin
                     for (int i = 0; i < NA; i++) sum_in[i] = '0;
                     lg_in  = '0;
                     cnt_in = '0;
                  end
                  mrsn_pkg::CMD_LOAD: begin
                     if (cnt_ff < CNT_W'(MAX_TRIANGLES)) begin
                        crd_in   = req_crd;
                        waddr_in = wbase_w[ADDR_W-1:0];
                        k_in     = '0;
                        ax_in    = '0;
                        st_in    = ST_LOAD;
                     end
                  end
                  mrsn_pkg::CMD_READ: begin
                     idx_in = req_tdata[IW-1:0];
                     st_in  = ST_CHECK;
                  end
                  default: begin
                     st_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            sum_in[ax_ff] = sum_ff[ax_ff] + SMW'($signed(wcrd));
            if (wmag > lg_ff) lg_in = wmag;
            waddr_in = waddr_ff + ADDR_W'(1);
            if (k_ff == 4'd8) begin
               cnt_in = cnt_ff + CNT_W'(1);
               st_in  = ST_IDLE;
            end else begin
               k_in  = k_ff + 4'd1;
               ax_in = (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
            end
         end
         ST_CHECK: begin
            rbase_in = rbase_w[ADDR_W-1:0];
            den5_in  = DW'({lg_ff, 2'b00}) + DW'(lg_ff);
            ax_in    = '0;
            if (CMP_W'(idx_ff) >= CMP_W'(cnt_ff) || lg_ff == '0) begin
               st_in = ST_ZERO;
            end else begin
               st_in = ST_CEN;
            end
         end
         ST_CEN: begin
            st_in = ST_CEN_WAIT;
         end
         ST_CEN_WAIT: begin
            if (asts.done) begin
               cen_in[ax_ff] = mrsn_pkg::sat32(q_cur, s_cur[SMW-1]);
               if (ax_ff == 2'd2) begin
                  ax_in = '0;
                  k_in  = '0;
                  st_in = ST_VRD;
               end else begin
                  ax_in = ax_ff + 2'd1;
                  st_in = ST_CEN;
               end
            end
         end
         ST_VRD: begin
            st_in = ST_VDAT;
         end
         ST_VDAT: begin
            vneg_in = vd[CW];
            st_in   = ST_VWAIT;
         end
         ST_VWAIT: begin
            if (asts.done) begin
               v_in[k_ff] = mrsn_pkg::sat32(q_cur, vneg_ff);
               if (k_ff == 4'd8) begin
                  st_in = ST_EDGE;
               end else begin
                  k_in  = k_ff + 4'd1;
                  ax_in = (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
                  st_in = ST_VRD;
               end
            end
         end
         ST_EDGE: begin
            for (int i = 0; i < NA; i++) begin
               e1_in[i] = ed1[i][CW] ? -$signed(es1[i][EW-1:0]) : $signed(es1[i][EW-1:0]);
               e2_in[i] = ed2[i][CW] ? -$signed(es2[i][EW-1:0]) : $signed(es2[i][EW-1:0]);
            end
            stp_in = '0;
            st_in  = ST_CROSS;
         end
         ST_CROSS: begin
            if (stp_ff == 3'd0) begin
               for (int i = 0; i < NA; i++) c_in[i] = '0;
            end else if (stp_ff[0]) begin
               c_in[acc_i] = c_ff[acc_i] + prod_ff;
            end else begin
               c_in[acc_i] = c_ff[acc_i] - prod_ff;
            end
            stp_in = stp_ff + 3'd1;
            if (stp_ff == 3'd6) st_in = ST_ZCHK;
         end
         ST_ZCHK: begin
            for (int i = 0; i < NA; i++) begin
               m_in[i]    = c_ff[i][AW-1] ? -c_ff[i] : c_ff[i];
               cneg_in[i] = c_ff[i][AW-1];
            end
            if (c_ff[0] == '0 && c_ff[1] == '0 && c_ff[2] == '0) begin
               st_in = ST_ZERO;
            end else begin
               st_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (m_ff[0][AW-1:30] != '0 || m_ff[1][AW-1:30] != '0 ||
                m_ff[2][AW-1:30] != '0) begin
               for (int i = 0; i < NA; i++) m_in[i] = m_ff[i] >> 1;
            end else if (m_ff[0][29] == 1'b0 && m_ff[1][29] == 1'b0 &&
                         m_ff[2][29] == 1'b0) begin
               for (int i = 0; i < NA; i++) m_in[i] = m_ff[i] << 1;
            end else begin
               stp_in = '0;
               st_in  = ST_SQ;
            end
         end
         ST_SQ: begin
            if (stp_ff == 3'd0) begin
               s2_in = '0;
            end else begin
               s2_in = s2_ff + prod_ff;
            end
            stp_in = stp_ff + 3'd1;
            if (stp_ff == 3'd3) st_in = ST_SQRT_GO;
         end
         ST_SQRT_GO: begin
            st_in = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (asts.done) begin
               r_in  = a_res[CW-1:0];
               ax_in = '0;
               st_in = ST_NDIV;
            end
         end
         ST_NDIV: begin
            st_in = ST_NDIV_WAIT;
         end
         ST_NDIV_WAIT: begin
            if (asts.done) begin
               nrm_in[ax_ff] = qn;
               if (ax_ff == 2'd2) begin
                  st_in = ST_OUT;
               end else begin
                  ax_in = ax_ff + 2'd1;
                  st_in = ST_NDIV;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = '0;
               for (int i = 0; i < NC; i++) rsp_data_in[i*CW +: CW] = v_ff[i];
               for (int i = 0; i < NA; i++) rsp_data_in[NV_OFF + i*RW +: RW] = nrm_ff[i];
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         ST_ZERO: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = '0;
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         for (int i = 0; i < NA; i++) sum_ff[i] <= '0;
         lg_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         ax_ff        <= '0;
         stp_ff       <= '0;
      end else begin
         st_ff        <= st_in;
         sum_ff       <= sum_in;
         lg_ff        <= lg_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         ax_ff        <= ax_in;
         stp_ff       <= stp_in;
      end
      crd_ff      <= crd_in;
      idx_ff      <= idx_in;
      waddr_ff    <= waddr_in;
      rbase_ff    <= rbase_in;
      cen_ff      <= cen_in;
      den5_ff     <= den5_in;
      vneg_ff     <= vneg_in;
      v_ff        <= v_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      c_ff        <= c_in;
      m_ff        <= m_in;
      cneg_ff     <= cneg_in;
      prod_ff     <= prod_in;
      s2_ff       <= s2_in;
      r_ff        <= r_in;
      nrm_ff      <= nrm_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `MRSN_ASSERT_IMP(a_ready_unit_free, clock, reset, req_tready, !asts.busy)
   `MRSN_ASSERT_IMP(a_load_has_room, clock, reset, st_ff == ST_LOAD,
                    cnt_ff < CNT_W'(MAX_TRIANGLES))
   `MRSN_ASSERT_IMP(a_normal_in_range, clock, reset, rsp_tvalid,
                    ($signed(rsp_tdata[NV_OFF +: RW]) <= 18'sd65536) &&
                    ($signed(rsp_tdata[NV_OFF +: RW]) >= -18'sd65536))

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int STORE_DEPTH = 1024;
   localparam longint CYCLE_LIMIT = 10000000;
   localparam logic [mrsn_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic                          drain;
      logic [mrsn_pkg::CMD_W-1:0]    cmd;
      logic [mrsn_pkg::IDX_W-1:0]    idx;
      logic [8:0][31:0]              crd;
   } request_type;

   typedef struct packed {
      logic [8:0][31:0]     vtx;
      logic [2:0][17:0]     nrm;
   } triangle_out_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [mrsn_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [mrsn_pkg::CMD_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [mrsn_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   mesh_recenter_scale_normals uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   request_type      pending_requests[$];
   triangle_out_type normalized_due[$];
   request_type      cur_request;

   logic [31:0]                triangle_store[STORE_DEPTH*9];
   logic [mrsn_pkg::SUM_W-1:0] axis_sum[3];
   logic [31:0]                peak_mag;
   int                         tri_count;

   int     error_count = 0;
   int     results_seen = 0;
   longint cycle_count = 0;
   int     send_gap, recv_gap, long_hold;
   int     sent_items;
   logic   long_hold_done;

   function automatic longint unsigned mag64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint sat_coord(longint unsigned m, bit neg);
      if (neg) return m > 64'h8000_0000 ? -64'sh8000_0000 : -longint'(m);
      return m > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(m);
   endfunction

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic triangle_out_type normalize_triangle(int idx);
      triangle_out_type r;
      longint v[9], cen[3], e1[3], e2[3], c[3], s, d;
      longint unsigned m[3], top, den, q, s2, rt;
      int len;
      bit big;
      r = '0;
      big = 0;
      if (idx >= tri_count || peak_mag == 0) return r;
      for (int i = 0; i < 3; i++) begin
         s = longint'({{16{axis_sum[i][mrsn_pkg::SUM_W-1]}}, axis_sum[i]});
         q = (mag64(s) + (3 * tri_count) / 2) / (3 * tri_count);
         cen[i] = sat_coord(q, s < 0);
      end
      den = longint'(peak_mag) * 5;
      for (int i = 0; i < 9; i++) begin
         d = longint'($signed(triangle_store[idx*9+i])) - cen[i%3];
         v[i] = sat_coord(((mag64(d) << 18) + den / 2) / den, d < 0);
      end
      for (int i = 0; i < 3; i++) begin
         e1[i] = v[3+i] - v[i];
         e2[i] = v[6+i] - v[i];
         if (mag64(e1[i]) >= (64'd1 << 30) || mag64(e2[i]) >= (64'd1 << 30)) big = 1;
      end
      if (big)
         for (int i = 0; i < 3; i++) begin
            e1[i] = e1[i] < 0 ? -longint'(mag64(e1[i]) >> 3) : e1[i] >>> 3;
            e2[i] = e2[i] < 0 ? -longint'(mag64(e2[i]) >> 3) : e2[i] >>> 3;
         end
      c[0] = e1[1] * e2[2] - e1[2] * e2[1];
      c[1] = e1[2] * e2[0] - e1[0] * e2[2];
      c[2] = e1[0] * e2[1] - e1[1] * e2[0];
      if (c[0] == 0 && c[1] == 0 && c[2] == 0) return r;
      top = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = mag64(c[i]);
         if (m[i] > top) top = m[i];
      end
      len = 0;
      while (len < 64 && (top >> len) != 0) len++;
      for (int i = 0; i < 3; i++)
         m[i] = len > 30 ? m[i] >> (len - 30) : m[i] << (30 - len);
      s2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      rt = root64(s2);
      for (int i = 0; i < 9; i++) r.vtx[i] = v[i][31:0];
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << 16) + rt / 2) / rt;
         r.nrm[i] = c[i] < 0 ? 18'(-q) : 18'(q);
      end
      return r;
   endfunction

   task automatic apply_request(request_type rq);
      longint unsigned a;
      case (rq.cmd)
         mrsn_pkg::CMD_CLEAR: begin
            foreach (axis_sum[i]) axis_sum[i] = '0;
            peak_mag = 0;
            tri_count = 0;
         end
         mrsn_pkg::CMD_LOAD: begin
            if (tri_count < STORE_DEPTH) begin
               for (int i = 0; i < 9; i++) begin
                  triangle_store[tri_count*9+i] = rq.crd[i];
                  axis_sum[i%3] = axis_sum[i%3] + {{16{rq.crd[i][31]}}, rq.crd[i]};
                  a = mag64(longint'($signed(rq.crd[i])));
                  if (a > peak_mag) peak_mag = a[31:0];
               end
               tri_count++;
            end
         end
         mrsn_pkg::CMD_READ: normalized_due = {normalized_due, normalize_triangle(rq.idx)};
         default: ;
      endcase
   endtask

   // request generation
   int gen_count;

   task automatic add_pending(request_type rq);
      pending_requests = {pending_requests, rq};
   endtask

   function automatic logic [31:0] rand_coord(int scale);
      case (scale)
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return 32'($signed($urandom_range(0, 2 << scale)) - (1 << scale));
      endcase
   endfunction

   task automatic queue_request(logic [mrsn_pkg::CMD_W-1:0] cmd, int idx, int scale, bit drain);
      request_type rq;
      rq.drain = drain;
      rq.cmd = cmd;
      rq.idx = idx[mrsn_pkg::IDX_W-1:0];
      for (int i = 0; i < 9; i++) rq.crd[i] = rand_coord(scale);
      if (cmd == mrsn_pkg::CMD_CLEAR) gen_count = 0;
      if (cmd == mrsn_pkg::CMD_LOAD && gen_count < STORE_DEPTH) gen_count++;
      add_pending(rq);
   endtask

   task automatic queue_fixed_load(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      request_type rq;
      rq = '0;
      rq.cmd = mrsn_pkg::CMD_LOAD;
      for (int i = 0; i < 3; i++) begin
         rq.crd[3*i] = x + 32'(i * 65536);
         rq.crd[3*i+1] = y + 32'(i * 65536);
         rq.crd[3*i+2] = z + 32'(i * 65536);
      end
      if (gen_count < STORE_DEPTH) gen_count++;
      add_pending(rq);
   endtask

   initial begin
      int scale, seg_len, pick;
      gen_count = 0;
      // directed
      queue_request(mrsn_pkg::CMD_READ, 0, 10, 0);
      queue_request(CMD_SPARE, 5, 0, 0);
      begin
         request_type z;
         z = '0;
         z.cmd = mrsn_pkg::CMD_LOAD;
         add_pending(z);
         gen_count++;
      end
      queue_request(mrsn_pkg::CMD_READ, 0, 10, 0);
      queue_request(mrsn_pkg::CMD_LOAD, 0, 1, 0);
      queue_request(mrsn_pkg::CMD_LOAD, 0, 0, 0);
      queue_fixed_load(32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000);
      queue_request(mrsn_pkg::CMD_READ, 1, 10, 0);
      queue_request(mrsn_pkg::CMD_READ, 2, 10, 0);
      queue_request(mrsn_pkg::CMD_READ, 3, 10, 0);
      queue_request(mrsn_pkg::CMD_READ, 4, 10, 0);
      queue_request(mrsn_pkg::CMD_READ, 1023, 10, 0);
      begin
         request_type dg;
         dg = '0;
         dg.cmd = mrsn_pkg::CMD_LOAD;
         for (int i = 0; i < 9; i++) dg.crd[i] = 32'h0002_0000 * 32'(i % 3 + 1);
         add_pending(dg);
         gen_count++;
      end
      queue_request(mrsn_pkg::CMD_READ, 4, 10, 0);
      queue_request(mrsn_pkg::CMD_CLEAR, 0, 10, 1);
      queue_request(mrsn_pkg::CMD_READ, 0, 10, 0);
      queue_request(mrsn_pkg::CMD_LOAD, 0, 18, 0);
      queue_request(mrsn_pkg::CMD_READ, 0, 10, 0);
      // fill the store past its end
      queue_request(mrsn_pkg::CMD_CLEAR, 0, 10, 1);
      for (int i = 0; i < 1030; i++) begin
         queue_request(mrsn_pkg::CMD_LOAD, 0,
                       $urandom_range(0, 7) == 0 ? 0 : $urandom_range(10, 30), 0);
         if (i % 64 == 63)
            queue_request(mrsn_pkg::CMD_READ, $urandom_range(0, gen_count - 1), 10, 0);
      end
      queue_request(mrsn_pkg::CMD_READ, 1023, 10, 0);
      queue_request(mrsn_pkg::CMD_READ, 0, 10, 0);
      // random sets of few triangles
      while (pending_requests.size() < 1700) begin
         queue_request(mrsn_pkg::CMD_CLEAR, 0, 10, $urandom_range(0, 3) == 0);
         scale = $urandom_range(0, 5) == 0 ? 0 : $urandom_range(8, 30);
         seg_len = $urandom_range(1, 12);
         for (int i = 0; i < seg_len; i++) queue_request(mrsn_pkg::CMD_LOAD, 0, scale, 0);
         seg_len = $urandom_range(2, 10);
         for (int i = 0; i < seg_len; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
               queue_request(mrsn_pkg::CMD_READ, $urandom_range(0, gen_count - 1), 10, 0);
            else if (pick < 14)
               queue_request(mrsn_pkg::CMD_READ, $urandom_range(0, 1023), 10, 0);
            else if (pick < 18)
               queue_request(mrsn_pkg::CMD_LOAD, 0, scale, 0);
            else if (pick < 19)
               queue_request(CMD_SPARE, $urandom_range(0, 1023), 0, 0);
            else
               queue_request(mrsn_pkg::CMD_LOAD, 0, $urandom_range(0, 1) ? 1 : 0, 0);
         end
      end
   end

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
         req_tuser <= '0;
         send_gap <= 0;
         sent_items <= 0;
         foreach (axis_sum[i]) axis_sum[i] = '0;
         peak_mag = 0;
         tri_count = 0;
      end else begin
         if (req_tvalid && req_tready) apply_request(cur_request);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 0;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain && normalized_due.size() > 0)) begin
               cur_request = pending_requests.pop_front();
               req_tvalid <= 1;
               req_tuser <= cur_request.cmd;
               req_tdata <= {6'd0, cur_request.crd, cur_request.idx};
               send_gap <= ((sent_items / 64) % 3 == 0) ? 0 : $urandom_range(0, 17);
               sent_items <= sent_items + 1;
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   string field_names[12] = '{"out_a_x", "out_a_y", "out_a_z", "out_b_x", "out_b_y",
      "out_b_z", "out_c_x", "out_c_y", "out_c_z", "normal_x", "normal_y", "normal_z"};

   always @(posedge clock) begin
      triangle_out_type want, got;
      if (reset) begin
         rsp_tready <= 0;
         recv_gap <= 0;
         long_hold <= 0;
         long_hold_done <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.vtx = rsp_tdata[287:0];
            got.nrm = rsp_tdata[341:288];
            results_seen <= results_seen + 1;
            if (normalized_due.size() == 0) begin
               $error("result with no request outstanding");
               error_count++;
            end else begin
               want = normalized_due.pop_front();
               for (int i = 0; i < 9; i++)
                  if (got.vtx[i] !== want.vtx[i]) begin
                     $error("%s expected %0d got %0d", field_names[i],
                            $signed(want.vtx[i]), $signed(got.vtx[i]));
                     error_count++;
                  end
               for (int i = 0; i < 3; i++)
                  if (got.nrm[i] !== want.nrm[i]) begin
                     $error("%s expected %0d got %0d", field_names[9+i],
                            $signed(want.nrm[i]), $signed(got.nrm[i]));
                     error_count++;
                  end
            end
         end
         if (!long_hold_done && results_seen == 12) begin
            long_hold_done <= 1;
            long_hold <= 6000;
            rsp_tready <= 0;
         end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            rsp_tready <= 0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 0;
         end else if (rsp_tvalid && rsp_tready) begin
            recv_gap <= ((results_seen / 32) % 3 == 1) ? 0 : $urandom_range(0, 17);
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      wait (pending_requests.size() == 0 && !req_tvalid && send_gap == 0);
      wait (normalized_due.size() == 0);
      repeat (1200) @(posedge clock);
      if (error_count == 0 && normalized_due.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mrsn_pkg.sv
rtl/core/mrsn_ram.sv
rtl/core/mrsn_arith.sv
rtl/core/mesh_recenter_scale_normals.sv
dv/testbench.sv
